### sv/trigger_sequencer_assert.svh
// Assertion macros shared by the trigger sequencer checkers.
// Each macro expands to one concurrent assertion clocked on clk with rst as disable.
`ifndef TRIGGER_SEQUENCER_ASSERT_SVH
`define TRIGGER_SEQUENCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSEQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tseq_pkg.sv
// Package for the trigger sequencer: codes, register map and item structs.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tseq_pkg;

  localparam int CHANNELS_DEF = 2;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int DELAY_W      = 22;
  localparam int TIME_W       = 32;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 16;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_INIT = 2'd1,
    ST_TRIG = 2'd2,
    ST_EXEC = 2'd3
  } state_t;

  typedef enum logic [2:0] {
    REQ_INITIATE = 3'd0,
    REQ_SW_TRIG  = 3'd1,
    REQ_PIN      = 3'd2,
    REQ_TICK     = 3'd3,
    REQ_FINISH   = 3'd4,
    REQ_ABORT    = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_FAIL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SRC_IMMEDIATE = 2'd0,
    SRC_MANUAL    = 2'd1,
    SRC_BUS       = 2'd2,
    SRC_PIN       = 2'd3
  } source_t;

  typedef enum logic [2:0] {
    REG_TRIG_SOURCE = 3'd0,
    REG_DELAY       = 3'd1,
    REG_CONTINUOUS  = 3'd2,
    REG_POLARITY    = 3'd3,
    REG_LIST_MASK   = 3'd4,
    REG_COUPLED     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         trigger_source;
    logic [DELAY_W-1:0] delay_ms;
    logic               continuous_enable;
    logic               pin_polarity;
    logic [1:0]         list_mode_mask;
    logic               coupled;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [TIME_W-1:0] now_ms;
    logic [1:0]        trig_source;
    logic              check_now;
    logic              pin_level;
    logic              channel_index;
    logic [2:0]        check_code;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] fail_code;
    logic [1:0] trig_state;
    logic       started;
    logic       all_done;
    logic [1:0] busy_mask;
  } result_t;

endpackage

### sv/trigger_sequencer.sv
// Trigger sequencer top level: stream ports, input and result registers.
// Depends on tseq_pkg, tseq_cfg and tseq_core.
`timescale 1ns / 1ps

// The trigger sequencer takes one event item per clock cycle on the slave
// stream while m_tready holds and returns exactly one result item for each
// on the master stream. An item first lands in an input register; the
// state machine then evaluates it combinationally against the current
// state and writes the result register, so the sustained rate is one item
// per cycle while the output is not stalled, set by that single evaluation
// stage. The result register and the input register together let a new item be
// taken while an earlier result still waits for m_tready. The event kind
// (initiate, software trigger, pin sample, tick, channel finished, abort)
// travels in s_tuser, the result status in m_tuser. Configuration registers
// sit on the APB port at byte addresses 0x00 (trigger source), 0x04 (delay
// in ms), 0x08 (continuous), 0x0C (pin polarity), 0x10 (list mode mask) and
// 0x14 (coupled); write them only while no item is in flight.

module trigger_sequencer #(
  parameter int CHANNELS = tseq_pkg::CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // APB configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tseq_pkg::ADDR_W-1:0]      paddr,
  input  logic [tseq_pkg::DATA_W-1:0]      pwdata,
  output logic [tseq_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  // Event stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // now_ms[31:0], trig_source[33:32], check_now[34], pin_level[35],
  // channel_index[36], check_code[39:37]
  input  logic [tseq_pkg::IN_TDATA_W-1:0]  s_tdata,
  // req_type[2:0]
  input  logic [2:0]                       s_tuser,
  // Result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // fail_code[2:0], trig_state[4:3], started[5], all_done[6],
  // busy_mask[8:7], zero fill[15:9]
  output logic [tseq_pkg::OUT_TDATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [1:0]                       m_tuser
);
  import tseq_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    advance;
  result_t core_result;
  result_t out_result;

  tseq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tseq_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (core_result)
  );

  // The held item moves on whenever the result register is free or being
  // emptied this cycle; the input register refills in the same cycle.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.req_type      <= s_tuser;
      in_item.now_ms        <= s_tdata[31:0];
      in_item.trig_source   <= s_tdata[33:32];
      in_item.check_now     <= s_tdata[34];
      in_item.pin_level     <= s_tdata[35];
      in_item.channel_index <= s_tdata[36];
      in_item.check_code    <= s_tdata[39:37];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_tuser = out_result.status;
  assign m_tdata = {7'd0, out_result.busy_mask, out_result.all_done, out_result.started,
                    out_result.trig_state, out_result.fail_code};

endmodule

### sv/tseq_cfg.sv
// Configuration register file of the trigger sequencer, written over APB.
// Depends on tseq_pkg for the register map and the cfg_t struct.
`timescale 1ns / 1ps

module tseq_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tseq_pkg::ADDR_W-1:0]  paddr,
  input  logic [tseq_pkg::DATA_W-1:0]  pwdata,
  output logic [tseq_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output tseq_pkg::cfg_t               cfg
);
  import tseq_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_TRIG_SOURCE: cfg.trigger_source    <= pwdata[1:0];
        REG_DELAY:       cfg.delay_ms          <= pwdata[DELAY_W-1:0];
        REG_CONTINUOUS:  cfg.continuous_enable <= pwdata[0];
        REG_POLARITY:    cfg.pin_polarity      <= pwdata[0];
        REG_LIST_MASK:   cfg.list_mode_mask    <= pwdata[1:0];
        REG_COUPLED:     cfg.coupled           <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TRIG_SOURCE: prdata = {30'd0, cfg.trigger_source};
      REG_DELAY:       prdata = {{(DATA_W-DELAY_W){1'b0}}, cfg.delay_ms};
      REG_CONTINUOUS:  prdata = {31'd0, cfg.continuous_enable};
      REG_POLARITY:    prdata = {31'd0, cfg.pin_polarity};
      REG_LIST_MASK:   prdata = {30'd0, cfg.list_mode_mask};
      REG_COUPLED:     prdata = {31'd0, cfg.coupled};
      default:         prdata = '0;
    endcase
  end

endmodule

### sv/tseq_core.sv
// Trigger state machine, trigger time stamp, pin history and channel busy flags.
// Evaluates one item per step; depends on tseq_pkg.
`timescale 1ns / 1ps

module tseq_core #(
  parameter int CHANNELS = tseq_pkg::CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tseq_pkg::item_t   item,
  input  tseq_pkg::cfg_t    cfg,
  output tseq_pkg::result_t result
);
  import tseq_pkg::*;

  state_t              seq_state, seq_state_next;
  logic [TIME_W-1:0]   trig_stamp, trig_stamp_next;
  logic                last_pin, last_pin_next;
  logic [CHANNELS-1:0] busy, busy_next;

  req_t                req;
  logic [TIME_W-1:0]   elapsed;
  logic                delay_due;
  logic                pin_edge;
  logic                trig_req;
  logic [1:0]          trig_src;
  logic                trig_ok;
  logic                start_try;
  logic                start_go;
  logic                init_arm;
  logic                code_bad;
  logic                fin_ok;
  logic                fin_done;
  logic                start_done;
  logic [CHANNELS-1:0] list_vec;
  logic [CHANNELS-1:0] clr_vec;
  logic [CHANNELS-1:0] busy_fin;
  logic [CHANNELS-1:0] start_busy;
  state_t              rest_state;

  // Only channels 0 and 1 have a list mode bit.
  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    if (i < 2) begin : g_list
      assign list_vec[i] = cfg.list_mode_mask[i];
    end else begin : g_nolist
      assign list_vec[i] = 1'b0;
    end
    assign clr_vec[i] = cfg.coupled || (int'(item.channel_index) == i);
  end

  // Event decode.
  always_comb begin
    req        = req_t'(item.req_type);
    code_bad   = item.check_code != 3'd0;
    elapsed    = item.now_ms - trig_stamp;
    delay_due  = elapsed > {{(TIME_W-DELAY_W){1'b0}}, cfg.delay_ms};
    pin_edge   = cfg.pin_polarity ? (!item.pin_level && last_pin)
                                  : (item.pin_level && !last_pin);
    trig_req   = (req == REQ_SW_TRIG) || ((req == REQ_PIN) && pin_edge);
    trig_src   = (req == REQ_PIN) ? SRC_PIN : item.trig_source;
    trig_ok    = trig_req && (trig_src == cfg.trigger_source) && (seq_state == ST_INIT);
    start_try  = ((req == REQ_INITIATE) && (cfg.trigger_source == SRC_IMMEDIATE)) ||
                 ((req == REQ_TICK) && (seq_state == ST_TRIG) && delay_due);
    start_go   = start_try && !code_bad;
    init_arm   = (req == REQ_INITIATE) && (cfg.trigger_source != SRC_IMMEDIATE);
    // Coupled channels follow channel 0; otherwise each non-list channel
    // finishes as soon as it starts.
    start_busy = cfg.coupled ? {CHANNELS{list_vec[0]}} : list_vec;
    start_done = start_busy == '0;
    fin_ok     = (req == REQ_FINISH) && (seq_state == ST_EXEC) &&
                 ((CHANNELS > 1) || !item.channel_index);
    busy_fin   = busy & ~clr_vec;
    fin_done   = fin_ok && (busy_fin == '0);
    rest_state = cfg.continuous_enable ? ST_INIT : ST_IDLE;
  end

  // Next state.
  always_comb begin
    seq_state_next = seq_state;
    if (req == REQ_ABORT) begin
      seq_state_next = ST_IDLE;
    end else if (start_go) begin
      seq_state_next = start_done ? rest_state : ST_EXEC;
    end else if (init_arm && !code_bad) begin
      seq_state_next = ST_INIT;
    end else if (trig_ok) begin
      seq_state_next = ST_TRIG;
    end else if (fin_done) begin
      seq_state_next = rest_state;
    end
  end

  // Data registers and result fields. The check_now field is not read, so
  // check_now never starts execution.
  always_comb begin
    trig_stamp_next = trig_ok ? item.now_ms : trig_stamp;
    last_pin_next   = (req == REQ_PIN) ? item.pin_level : last_pin;
    busy_next       = busy;
    if (req == REQ_ABORT) begin
      busy_next = '0;
    end else if (start_go) begin
      busy_next = start_busy;
    end else if (fin_ok) begin
      busy_next = busy_fin;
    end

    result.status    = STAT_OK;
    result.fail_code = 3'd0;
    if ((start_try || init_arm) && code_bad) begin
      result.status    = STAT_FAIL;
      result.fail_code = item.check_code;
    end else if (trig_req && !trig_ok) begin
      result.status = STAT_IGNORED;
    end
    result.trig_state = seq_state_next;
    result.started    = start_go;
    result.all_done   = (start_go && start_done) || fin_done;
    // Only channels 0 and 1 are shown; a single channel leaves bit 1 clear.
    result.busy_mask  = 2'(busy_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state  <= ST_IDLE;
      trig_stamp <= '0;
      last_pin   <= 1'b0;
      busy       <= '0;
    end else if (step) begin
      seq_state  <= seq_state_next;
      trig_stamp <= trig_stamp_next;
      last_pin   <= last_pin_next;
      busy       <= busy_next;
    end
  end

endmodule

### sv/tseq_checker.sv
// Port-level checker for the trigger sequencer, bound to the top level.
// Depends on tseq_pkg and trigger_sequencer_assert.svh.
`timescale 1ns / 1ps
`include "trigger_sequencer_assert.svh"

module tseq_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [tseq_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [1:0]                       m_tuser
);
  import tseq_pkg::*;

  logic [2:0]             fail_code;
  logic [1:0]             trig_state;
  logic                   started;
  logic                   all_done;
  logic [1:0]             busy_mask;
  logic [OUT_TDATA_W+1:0] out_word;
  logic                   stalled;
  logic                   failed;
  logic                   open_start;
  logic                   at_rest;

  assign fail_code  = m_tdata[2:0];
  assign trig_state = m_tdata[4:3];
  assign started    = m_tdata[5];
  assign all_done   = m_tdata[6];
  assign busy_mask  = m_tdata[8:7];
  assign out_word   = {m_tuser, m_tdata};
  assign stalled    = m_tvalid && !m_tready;
  assign failed     = m_tuser == STAT_FAIL;
  assign open_start = m_tvalid && started && !all_done;
  assign at_rest    = (busy_mask == 2'd0) &&
                      ((trig_state == ST_IDLE) || (trig_state == ST_INIT));

  // A stalled result item must hold until taken.
  `TSEQ_ASSERT_NEXT(a_hold, stalled, m_tvalid && $stable(out_word), "stalled result changed")

  // A failure code is only reported together with a failed check.
  `TSEQ_ASSERT_SAME(a_fail_code, m_tvalid && !failed, fail_code == 3'd0, "stray fail code")

  // A start that did not complete at once leaves the sequencer executing.
  `TSEQ_ASSERT_SAME(a_start_exec, open_start, trig_state == ST_EXEC, "start not executing")

  // Completion frees every channel and leaves idle or initiated.
  `TSEQ_ASSERT_SAME(a_done_idle, m_tvalid && all_done, at_rest, "completion left channels busy")

endmodule

bind trigger_sequencer tseq_checker u_tseq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
